// ===== hw/rtl/bvcm_pkg.sv =====
// Package: shared types, constants and register indexes of the battery monitor.
`timescale 1ns / 1ps

package bvcm_pkg;

    // Default depth of the averaging ring
    localparam int AVG_DEPTH_DEF = 8;

    // Field widths
    localparam int MV_W     = 13;
    localparam int ADC_W    = 12;
    localparam int STABLE_W = 7;
    localparam int TOGGLE_W = 4;
    localparam int BAND_W   = 8;
    localparam int UPD_W    = 8;
    localparam int PSTATE_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_HIGH_MV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LOW_MV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_MV  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_EVERY = 3'd5;

    // Register reset values
    localparam logic [STABLE_W-1:0] RST_STABLE_COUNT = 7'd100;
    localparam logic [TOGGLE_W-1:0] RST_TOGGLE_LIMIT = 4'd10;
    localparam logic [MV_W-1:0]     RST_FULL_HIGH_MV = 13'd4200;
    localparam logic [MV_W-1:0]     RST_FULL_LOW_MV  = 13'd4100;
    localparam logic [BAND_W-1:0]   RST_DEADBAND_MV  = 8'd10;
    localparam logic [UPD_W-1:0]    RST_UPDATE_EVERY = 8'd5;

    // Counter limits
    localparam logic [STABLE_W-1:0] STABLE_MAX = 7'd127;
    localparam logic [TOGGLE_W-1:0] TOGGLE_MAX = 4'd15;
    localparam logic [UPD_W-1:0]    UPD_MAX    = 8'd255;

    // Power states
    localparam logic [PSTATE_W-1:0] ST_CHARGING   = 2'd0;
    localparam logic [PSTATE_W-1:0] ST_FULL       = 2'd1;
    localparam logic [PSTATE_W-1:0] ST_ON_BATTERY = 2'd2;
    localparam logic [PSTATE_W-1:0] ST_NO_BATTERY = 2'd3;

    typedef struct packed {
        logic             charge_pin;
        logic             adc_valid;
        logic [ADC_W-1:0] adc_millivolts;
        logic             ack_value;
        logic             ack_state;
    } t_in_item;

    typedef struct packed {
        logic [MV_W-1:0]     displayed_mv;
        logic [MV_W-1:0]     raw_mv;
        logic [PSTATE_W-1:0] power_state;
        logic                value_changed;
        logic                state_changed;
    } t_out_item;

endpackage

// ===== hw/rtl/bvcm_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module bvcm_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bvcm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ring average.
`timescale 1ns / 1ps

module bvcm_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {r_rem, r_quot[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    // Control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_rem  <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/battery_voltage_and_charge_monitor.sv =====
// Top level: ADC averaging ring, displayed-voltage filter and charge-pin state machine.
// An item passes from S_IDLE through S_RD for an ADC reading and S_DIV when the update
// check runs, then S_PIN and S_OUT into the output register; the bit-serial divider for
// sum / fill count makes the update check the long case.
// Throughput: one item at a time; the next item is accepted once the result is in the
// output register. Reset is synchronous and active low; the ring RAM is not cleared.
`timescale 1ns / 1ps

module battery_voltage_and_charge_monitor
    import bvcm_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = AVG_DEPTH > 1 ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W  = MV_W + $clog2(AVG_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // Configuration registers
    logic [STABLE_W-1:0] r_stable_count;
    logic [TOGGLE_W-1:0] r_toggle_limit;
    logic [MV_W-1:0]     r_full_high;
    logic [MV_W-1:0]     r_full_low;
    logic [BAND_W-1:0]   r_deadband;
    logic [UPD_W-1:0]    r_update_every;

    // Control and monitor state
    logic [2:0]          r_state,  n_state;
    logic [SUM_W-1:0]    r_sum,    n_sum;
    logic [FILL_W-1:0]   r_fill,   n_fill;
    logic [IDX_W-1:0]    r_widx,   n_widx;
    logic [MV_W-1:0]     r_shown,  n_shown;
    logic [MV_W-1:0]     r_raw,    n_raw;
    logic [UPD_W-1:0]    r_upd,    n_upd;
    logic [STABLE_W-1:0] r_stable, n_stable;
    logic [TOGGLE_W-1:0] r_toggle, n_toggle;
    logic                r_prev,   n_prev;
    logic [PSTATE_W-1:0] r_pstate, n_pstate;
    logic                r_vflag,  n_vflag;
    logic                r_sflag,  n_sflag;
    logic                r_out_valid, n_out_valid;

    // Payload registers
    t_in_item            r_in;
    t_out_item           r_out;

    logic                accept;
    logic                out_load;
    logic [MV_W-1:0]     mv;
    logic [MV_W-1:0]     old_mv;
    logic                ram_we;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_quot;
    logic [MV_W-1:0]     avg;
    logic [MV_W-1:0]     diff;
    logic [STABLE_W-1:0] stable_inc;
    logic [PSTATE_W-1:0] eval_state;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Battery millivolts are twice the divider reading
    assign mv = {r_in.adc_millivolts, 1'b0};

    // Sample ring, read of the outgoing entry issued on accept of an ADC reading
    assign ram_we = (r_state == S_RD);

    bvcm_ram #(
        .WIDTH (MV_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx),
        .i_wdata (mv),
        .i_re    (accept && i_in_data.adc_valid),
        .i_raddr (r_widx),
        .o_rdata (old_mv)
    );

    // Average divider
    bvcm_div #(
        .NUM_W (SUM_W),
        .DEN_W (FILL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_sum),
        .i_den   (n_fill),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign avg  = div_quot[MV_W-1:0];
    assign diff = (avg > r_shown) ? avg - r_shown : r_shown - avg;

    // Debounce helpers
    assign stable_inc = (r_stable < STABLE_MAX) ? r_stable + 1'b1 : r_stable;

    always_comb begin
        if (r_in.charge_pin) begin
            if (r_shown >= r_full_high) begin
                eval_state = ST_FULL;
            end else if (r_shown >= r_full_low && r_pstate == ST_CHARGING) begin
                eval_state = ST_FULL;
            end else begin
                eval_state = ST_ON_BATTERY;
            end
        end else begin
            eval_state = ST_CHARGING;
        end
    end

    // Sequencer: next state of the monitor
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_fill      = r_fill;
        n_widx      = r_widx;
        n_shown     = r_shown;
        n_raw       = r_raw;
        n_upd       = r_upd;
        n_stable    = r_stable;
        n_toggle    = r_toggle;
        n_prev      = r_prev;
        n_pstate    = r_pstate;
        n_vflag     = r_vflag;
        n_sflag     = r_sflag;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;

        // Drop the output item once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.ack_value) begin
                        n_vflag = 1'b0;
                    end
                    if (i_in_data.ack_state) begin
                        n_sflag = 1'b0;
                    end
                    n_state = i_in_data.adc_valid ? S_RD : S_PIN;
                end
            end
            S_RD: begin
                // Add the reading to the ring and the running sum
                n_raw = mv;
                if (r_fill == FILL_W'(AVG_DEPTH)) begin
                    n_sum = r_sum - SUM_W'(old_mv) + SUM_W'(mv);
                end else begin
                    n_sum  = r_sum + SUM_W'(mv);
                    n_fill = r_fill + 1'b1;
                end
                n_widx = (r_widx == IDX_W'(AVG_DEPTH - 1)) ? '0 : r_widx + 1'b1;
                n_upd  = (r_upd < UPD_MAX) ? r_upd + 1'b1 : r_upd;
                if (r_shown == '0 || n_upd >= r_update_every) begin
                    n_upd     = '0;
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_PIN;
                end
            end
            S_DIV: begin
                // Move the display only past the deadband
                if (div_done) begin
                    if (diff > MV_W'(r_deadband)) begin
                        n_shown = avg;
                        n_vflag = 1'b1;
                    end
                    n_state = S_PIN;
                end
            end
            S_PIN: begin
                if (r_in.charge_pin == r_prev) begin
                    if (r_stable < r_stable_count || r_vflag) begin
                        n_stable = stable_inc;
                        if (stable_inc >= r_stable_count && eval_state != r_pstate) begin
                            n_pstate = eval_state;
                            n_vflag  = 1'b1;
                            n_sflag  = 1'b1;
                        end
                    end
                end else begin
                    // Count a toggle, declare no battery past the limit
                    n_stable = '0;
                    if (r_pstate != ST_NO_BATTERY) begin
                        if (r_toggle >= r_toggle_limit) begin
                            n_pstate = ST_NO_BATTERY;
                            n_vflag  = 1'b1;
                            n_sflag  = 1'b1;
                            n_toggle = '0;
                        end else if (r_toggle < TOGGLE_MAX) begin
                            n_toggle = r_toggle + 1'b1;
                        end
                    end
                    n_prev = r_in.charge_pin;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_fill      <= '0;
            r_widx      <= '0;
            r_shown     <= '0;
            r_raw       <= '0;
            r_upd       <= '0;
            r_stable    <= '0;
            r_toggle    <= '0;
            r_prev      <= 1'b1;
            r_pstate    <= ST_CHARGING;
            r_vflag     <= 1'b0;
            r_sflag     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_fill      <= n_fill;
            r_widx      <= n_widx;
            r_shown     <= n_shown;
            r_raw       <= n_raw;
            r_upd       <= n_upd;
            r_stable    <= n_stable;
            r_toggle    <= n_toggle;
            r_prev      <= n_prev;
            r_pstate    <= n_pstate;
            r_vflag     <= n_vflag;
            r_sflag     <= n_sflag;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_count <= RST_STABLE_COUNT;
            r_toggle_limit <= RST_TOGGLE_LIMIT;
            r_full_high    <= RST_FULL_HIGH_MV;
            r_full_low     <= RST_FULL_LOW_MV;
            r_deadband     <= RST_DEADBAND_MV;
            r_update_every <= RST_UPDATE_EVERY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STABLE_COUNT: r_stable_count <= i_cfg_data[STABLE_W-1:0];
                CFG_TOGGLE_LIMIT: r_toggle_limit <= i_cfg_data[TOGGLE_W-1:0];
                CFG_FULL_HIGH_MV: r_full_high    <= i_cfg_data[MV_W-1:0];
                CFG_FULL_LOW_MV:  r_full_low     <= i_cfg_data[MV_W-1:0];
                CFG_DEADBAND_MV:  r_deadband     <= i_cfg_data[BAND_W-1:0];
                CFG_UPDATE_EVERY: r_update_every <= i_cfg_data[UPD_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the input item and load the output item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        if (out_load) begin
            r_out.displayed_mv  <= r_shown;
            r_out.raw_mv        <= r_raw;
            r_out.power_state   <= r_pstate;
            r_out.value_changed <= r_vflag;
            r_out.state_changed <= r_sflag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/testbench.sv =====
// Testbench: battery monitor checked item by item against a local behavioural model.
`timescale 1ns / 1ps

module testbench;
    import bvcm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int N_DIRECTED  = 21;
    localparam int N_PHASES    = 5;

    typedef struct packed {
        logic [STABLE_W-1:0] stable_cnt;
        logic [TOGGLE_W-1:0] toggle_lim;
        logic [MV_W-1:0]     full_hi;
        logic [MV_W-1:0]     full_lo;
        logic [BAND_W-1:0]   band;
        logic [UPD_W-1:0]    every;
    } t_settings;

    typedef struct packed {
        logic      has_want;
        t_out_item want;
    } t_pinned;

    typedef struct packed {
        t_in_item  tick;
        logic      has_want;
        t_out_item want;
    } t_directed_row;

    // Opening sequence under reset settings: first reading, ack, toggles into no battery
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        '{'{1'b1, 1'b0, 12'd0,    1'b0, 1'b0}, 1'b1, '{13'd0,    13'd0,    ST_CHARGING,   1'b0, 1'b0}},
        '{'{1'b1, 1'b1, 12'd4095, 1'b0, 1'b0}, 1'b1, '{13'd8190, 13'd8190, ST_CHARGING,   1'b1, 1'b0}},
        '{'{1'b1, 1'b1, 12'd0,    1'b0, 1'b0}, 1'b1, '{13'd8190, 13'd0,    ST_CHARGING,   1'b1, 1'b0}},
        '{'{1'b1, 1'b1, 12'd4095, 1'b1, 1'b0}, 1'b1, '{13'd8190, 13'd8190, ST_CHARGING,   1'b0, 1'b0}},
        '{'{1'b0, 1'b0, 12'd0,    1'b0, 1'b0}, 1'b1, '{13'd8190, 13'd8190, ST_CHARGING,   1'b0, 1'b0}},
        '{'{1'b1, 1'b0, 12'd0,    1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, 12'd0,    1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b0, 12'hAAA,  1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 12'h555,  1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b0, 12'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 12'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b0, 12'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 12'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b0, 12'd0,    1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 12'd0,    1'b0, 1'b0}, 1'b1, '{13'd8190, 13'd8190, ST_NO_BATTERY, 1'b1, 1'b1}},
        '{'{1'b0, 1'b0, 12'd0,    1'b1, 1'b1}, 1'b1, '{13'd8190, 13'd8190, ST_NO_BATTERY, 1'b0, 1'b0}},
        '{'{1'b1, 1'b0, 12'd0,    1'b0, 1'b0}, 1'b1, '{13'd8190, 13'd8190, ST_NO_BATTERY, 1'b0, 1'b0}},
        '{'{1'b1, 1'b1, 12'd4095, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b1, 12'd2048, 1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b1, 12'd1,    1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b1, 12'd4095, 1'b1, 1'b1}, 1'b0, '0}
    };

    // Fixed register settings: minimums, maximums and a few in between
    localparam t_settings PHASES [N_PHASES] = '{
        '{7'd1,   4'd0,  13'd4200, 13'd4100, 8'd0,   8'd1},
        '{7'd127, 4'd15, 13'd8191, 13'd8191, 8'd255, 8'd255},
        '{7'd3,   4'd2,  13'd3000, 13'd2800, 8'd5,   8'd3},
        '{7'd8,   4'd5,  13'd0,    13'd0,    8'd20,  8'd2},
        '{7'd2,   4'd15, 13'd6000, 13'd5000, 8'd100, 8'd7}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Model copy of the registers
    logic [STABLE_W-1:0] cfg_stable;
    logic [TOGGLE_W-1:0] cfg_toggle;
    logic [MV_W-1:0]     cfg_full_high;
    logic [MV_W-1:0]     cfg_full_low;
    logic [BAND_W-1:0]   cfg_deadband;
    logic [UPD_W-1:0]    cfg_update_every;

    // Model copy of the monitor state
    logic [MV_W-1:0]     ring_mv [AVG_DEPTH_DEF];
    logic [15:0]         sum_mv;
    logic [3:0]          fill_cnt;
    int                  wr_idx;
    logic [MV_W-1:0]     shown_mv;
    logic [MV_W-1:0]     raw_mv;
    logic [UPD_W-1:0]    upd_cnt;
    logic [STABLE_W-1:0] stab_cnt;
    logic [TOGGLE_W-1:0] tog_cnt;
    logic                prev_pin;
    logic [PSTATE_W-1:0] pstate;
    logic                vflag;
    logic                sflag;

    t_out_item status_due_q [$];
    t_pinned   pinned_due_q [$];
    int        items_sent   = 0;
    int        results_seen = 0;
    int        mismatches   = 0;
    int        idle_cycles  = 0;
    int        ready_hold   = 0;
    bit        steady       = 1'b0;

    battery_voltage_and_charge_monitor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the model by one pin tick and return the status it reports
    task automatic step_monitor(input t_in_item tick, output t_out_item res);
        logic [MV_W-1:0]     mv;
        logic [15:0]         avg;
        logic [15:0]         delta;
        logic [PSTATE_W-1:0] nxt;
        if (tick.ack_value) vflag = 1'b0;
        if (tick.ack_state) sflag = 1'b0;
        // Reading: ring and running sum, then the displayed-voltage check
        if (tick.adc_valid) begin
            mv = {tick.adc_millivolts, 1'b0};
            raw_mv = mv;
            if (fill_cnt < AVG_DEPTH_DEF) begin
                sum_mv = sum_mv + mv;
                fill_cnt = fill_cnt + 1'b1;
            end else begin
                sum_mv = sum_mv - ring_mv[wr_idx] + mv;
            end
            ring_mv[wr_idx] = mv;
            wr_idx = (wr_idx + 1) % AVG_DEPTH_DEF;
            avg = sum_mv / fill_cnt;
            if (upd_cnt != UPD_MAX) upd_cnt = upd_cnt + 1'b1;
            if (shown_mv == '0 || upd_cnt >= cfg_update_every) begin
                upd_cnt = '0;
                delta = (avg > shown_mv) ? avg - shown_mv : shown_mv - avg;
                if (delta > cfg_deadband) begin
                    shown_mv = avg[MV_W-1:0];
                    vflag = 1'b1;
                end
            end
        end
        // Pin: debounce, evaluate when stable, count toggles otherwise
        if (tick.charge_pin == prev_pin) begin
            if (stab_cnt < cfg_stable || vflag) begin
                if (stab_cnt != STABLE_MAX) stab_cnt = stab_cnt + 1'b1;
                if (stab_cnt >= cfg_stable) begin
                    if (!tick.charge_pin)
                        nxt = ST_CHARGING;
                    else if (shown_mv >= cfg_full_high)
                        nxt = ST_FULL;
                    else if (shown_mv >= cfg_full_low && pstate == ST_CHARGING)
                        nxt = ST_FULL;
                    else
                        nxt = ST_ON_BATTERY;
                    if (nxt != pstate) begin
                        pstate = nxt;
                        vflag = 1'b1;
                        sflag = 1'b1;
                    end
                end
            end
        end else begin
            stab_cnt = '0;
            if (pstate != ST_NO_BATTERY) begin
                if (tog_cnt >= cfg_toggle) begin
                    pstate = ST_NO_BATTERY;
                    vflag = 1'b1;
                    sflag = 1'b1;
                    tog_cnt = '0;
                end else if (tog_cnt != TOGGLE_MAX) begin
                    tog_cnt = tog_cnt + 1'b1;
                end
            end
            prev_pin = tick.charge_pin;
        end
        res.displayed_mv  = shown_mv;
        res.raw_mv        = raw_mv;
        res.power_state   = pstate;
        res.value_changed = vflag;
        res.state_changed = sflag;
    endtask

    // Write all six registers, one per cycle, and mirror them in the model
    task automatic apply_settings(input t_settings s);
        logic [CFG_IDX_W-1:0]  idx  [6];
        logic [CFG_DATA_W-1:0] vals [6];
        idx  = '{CFG_STABLE_COUNT, CFG_TOGGLE_LIMIT, CFG_FULL_HIGH_MV,
                 CFG_FULL_LOW_MV, CFG_DEADBAND_MV, CFG_UPDATE_EVERY};
        vals = '{CFG_DATA_W'(s.stable_cnt), CFG_DATA_W'(s.toggle_lim), s.full_hi,
                 s.full_lo, CFG_DATA_W'(s.band), CFG_DATA_W'(s.every)};
        cfg_stable       = s.stable_cnt;
        cfg_toggle       = s.toggle_lim;
        cfg_full_high    = s.full_hi;
        cfg_full_low     = s.full_lo;
        cfg_deadband     = s.band;
        cfg_update_every = s.every;
        for (int i = 0; i < 6; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Present one item after a random gap (none while steady) and hold it until it is taken
    task automatic send_tick(input t_in_item tick, input t_pinned pin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 17);
        pinned_due_q.push_back(pin);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tick;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Drop valid and hold until every expected status has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_seen != items_sent);
    endtask

    // Predict on every accepted item
    always @(posedge i_clk) begin : take_ticks
        t_pinned   pin;
        t_out_item pred;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pin = pinned_due_q.pop_front();
            step_monitor(i_in_data, pred);
            status_due_q.push_back(pin.has_want ? pin.want : pred);
        end
    end

    // Check each status against the oldest expectation and pace the ready
    always @(posedge i_clk) begin : take_status
        t_out_item want;
        int        stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_hold  <= 0;
        end else if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (status_due_q.size() == 0) begin
                $display("%0t: status with nothing pending: %p", $time, o_out_data);
                mismatches++;
            end else begin
                want = status_due_q.pop_front();
                if (o_out_data.displayed_mv !== want.displayed_mv) begin
                    $display("%0t: displayed_mv expected %0d got %0d", $time,
                             want.displayed_mv, o_out_data.displayed_mv);
                    mismatches++;
                end
                if (o_out_data.raw_mv !== want.raw_mv) begin
                    $display("%0t: raw_mv expected %0d got %0d", $time,
                             want.raw_mv, o_out_data.raw_mv);
                    mismatches++;
                end
                if (o_out_data.power_state !== want.power_state) begin
                    $display("%0t: power_state expected %0d got %0d", $time,
                             want.power_state, o_out_data.power_state);
                    mismatches++;
                end
                if (o_out_data.value_changed !== want.value_changed) begin
                    $display("%0t: value_changed expected %0b got %0b", $time,
                             want.value_changed, o_out_data.value_changed);
                    mismatches++;
                end
                if (o_out_data.state_changed !== want.state_changed) begin
                    $display("%0t: state_changed expected %0b got %0b", $time,
                             want.state_changed, o_out_data.state_changed);
                    mismatches++;
                end
            end
            stall = steady ? 0 : $urandom_range(0, 17);
            i_out_ready <= (stall == 0);
            ready_hold  <= stall;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1) i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        t_settings s;
        t_in_item  tick;
        int        n_items;
        int        run_left;
        logic      run_pin;
        int        base;
        int        mv;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;

        // Reset state of the model
        cfg_stable       = RST_STABLE_COUNT;
        cfg_toggle       = RST_TOGGLE_LIMIT;
        cfg_full_high    = RST_FULL_HIGH_MV;
        cfg_full_low     = RST_FULL_LOW_MV;
        cfg_deadband     = RST_DEADBAND_MV;
        cfg_update_every = RST_UPDATE_EVERY;
        for (int i = 0; i < AVG_DEPTH_DEF; i++) ring_mv[i] = '0;
        sum_mv   = '0;
        fill_cnt = '0;
        wr_idx   = 0;
        shown_mv = '0;
        raw_mv   = '0;
        upd_cnt  = '0;
        stab_cnt = '0;
        tog_cnt  = '0;
        prev_pin = 1'b1;
        pstate   = ST_CHARGING;
        vflag    = 1'b0;
        sflag    = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the opening table under reset settings
        for (int r = 0; r < N_DIRECTED; r++)
            send_tick(DIRECTED[r].tick, '{DIRECTED[r].has_want, DIRECTED[r].want});

        // Random phases, each under fresh register settings
        run_pin = 1'b1;
        for (int p = 0; p < N_PHASES + 2; p++) begin
            drain();
            repeat (25) @(posedge i_clk);
            if (p < N_PHASES) begin
                s = PHASES[p];
            end else begin
                s.stable_cnt = STABLE_W'($urandom_range(1, 12));
                s.toggle_lim = TOGGLE_W'($urandom_range(0, 15));
                s.full_hi    = MV_W'($urandom_range(0, 8191));
                s.full_lo    = MV_W'($urandom_range(0, 8191));
                s.band       = BAND_W'($urandom_range(0, 255));
                s.every      = UPD_W'($urandom_range(1, 20));
            end
            apply_settings(s);
            n_items  = (s.stable_cnt > 60) ? 150 : 65;
            run_left = 0;
            for (int k = 0; k < n_items; k++) begin
                steady = (k >= 20 && k < 35);
                if ($urandom_range(0, 49) == 0) drain();
                // Mostly runs long enough to settle, sometimes a short bounce
                if (run_left == 0) begin
                    run_pin = ~run_pin;
                    if ($urandom_range(0, 9) < 2)
                        run_left = $urandom_range(1, 3);
                    else
                        run_left = int'(cfg_stable) + $urandom_range(0, 20);
                end
                run_left--;
                // Readings cluster around the thresholds, with extremes and noise
                base = int'($urandom_range(0, 1) ? cfg_full_high : cfg_full_low) / 2;
                case ($urandom_range(0, 9))
                    0:       mv = 0;
                    1:       mv = 4095;
                    2, 3:    mv = $urandom_range(0, 4095);
                    default: mv = base + $urandom_range(0, 120) - 60;
                endcase
                if (mv < 0) mv = 0;
                if (mv > 4095) mv = 4095;
                tick.charge_pin     = run_pin;
                tick.adc_valid      = 1'($urandom_range(0, 1));
                tick.adc_millivolts = ADC_W'(mv);
                tick.ack_value      = ($urandom_range(0, 4) == 0);
                tick.ack_state      = ($urandom_range(0, 4) == 0);
                send_tick(tick, '0);
            end
            steady = 1'b0;
        end

        // Let the last status arrive, then settle
        drain();
        repeat (30) @(posedge i_clk);
        if (status_due_q.size() != 0)
            $display("%0t: %0d status items never arrived", $time, status_due_q.size());
        if (mismatches == 0 && status_due_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bvcm_pkg.sv
hw/rtl/bvcm_ram.sv
hw/rtl/bvcm_div.sv
hw/rtl/battery_voltage_and_charge_monitor.sv
tb/testbench.sv
